### hw/rtl/bilinear_image_scaler_core_defines.svh
// Assertion macros used by the bilinear scaler checker.
`ifndef BILINEAR_IMAGE_SCALER_CORE_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bilinear scaler check failed");

// Consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bilinear scaler check failed");

`endif

### hw/rtl/bis_pkg.sv
// Shared types and constants of the bilinear image scaler.
package bis_pkg;

    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int PIX_W      = CH_W * NCH;
    localparam int SRC_DIM_W  = 9;
    localparam int DST_DIM_W  = 12;
    localparam int STEP_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int PX_W       = STEP_W + DST_DIM_W;
    localparam int IX_W       = PX_W - FRAC_W;
    localparam int WGT_W      = FRAC_W + 1;
    localparam int ACC_P_W    = CH_W + WGT_W;
    localparam int ACC_W      = CH_W + FRAC_W;
    localparam int MIX_P_W    = ACC_W + WGT_W;
    localparam int SUM_W      = CH_W + 2 * FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd5;

    localparam logic [SRC_DIM_W-1:0] RST_SRC_DIM = 9'd256;
    localparam logic [DST_DIM_W-1:0] RST_DST_DIM = 12'd256;
    localparam logic [STEP_W-1:0]    RST_STEP    = 24'd65280;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COORD,
        ST_ROWS,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_ACC_D,
        ST_MIX_V,
        ST_MIX_H,
        ST_OUT
    } t_state;

    // Neighbors: A top-left, B top-right, C bottom-left, D bottom-right.
    typedef enum logic [1:0] {
        NBR_A,
        NBR_B,
        NBR_C,
        NBR_D
    } t_nbr;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic emit;
        logic latch_coord;
        logic latch_rows;
        logic rd_en;
        t_nbr rd_sel;
        logic acc_en;
        t_nbr acc_sel;
        logic mix_v;
        logic mix_h;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

### hw/rtl/bis_in_if.sv
// Input channel of the bilinear scaler: load or emit words.
interface bis_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output opcode, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink (input valid, input opcode, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

### hw/rtl/bis_out_if.sv
// Output channel of the bilinear scaler: interpolated pixel words.
interface bis_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_last, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input frame_last, output ready);
endinterface

### hw/rtl/bis_ctrl.sv
// Controller state machine that sequences loads and emits through the datapath.
module bis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_opcode,
    input  bis_pkg::t_stat i_stat,
    output bis_pkg::t_cmd  o_cmd
);
    import bis_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.rd_sel = NBR_A;
        o_cmd.acc_sel = NBR_A;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    if (i_in_opcode == OP_EMIT) begin
                        o_cmd.emit = 1'b1;
                        n_state = ST_COORD;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_COORD: begin
                o_cmd.latch_coord = 1'b1;
                n_state = ST_ROWS;
            end
            ST_ROWS: begin
                o_cmd.latch_rows = 1'b1;
                n_state = ST_RD_A;
            end
            ST_RD_A: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = NBR_A;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = NBR_B;
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_sel = NBR_A;
                n_state = ST_RD_C;
            end
            ST_RD_C: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = NBR_C;
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_sel = NBR_B;
                n_state = ST_RD_D;
            end
            ST_RD_D: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = NBR_D;
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_sel = NBR_C;
                n_state = ST_ACC_D;
            end
            ST_ACC_D: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_sel = NBR_D;
                n_state = ST_MIX_V;
            end
            ST_MIX_V: begin
                o_cmd.mix_v = 1'b1;
                n_state = ST_MIX_H;
            end
            ST_MIX_H: begin
                o_cmd.mix_h = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // Hold the finished pixel until the output register can take it.
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/bis_datapath.sv
// Datapath of the bilinear scaler: registers, frame store, counters and blend.
module bis_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bis_pkg::t_cmd                    i_cmd,
    output bis_pkg::t_stat                   o_stat,
    input  logic                             i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [bis_pkg::CH_W-1:0]         i_in_red,
    input  logic [bis_pkg::CH_W-1:0]         i_in_green,
    input  logic [bis_pkg::CH_W-1:0]         i_in_blue,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [bis_pkg::CH_W-1:0]         o_out_red,
    output logic [bis_pkg::CH_W-1:0]         o_out_green,
    output logic [bis_pkg::CH_W-1:0]         o_out_blue,
    output logic                             o_out_last
);
    import bis_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = $clog2(MAX_HEIGHT);
    localparam int SW_W        = $clog2(MAX_WIDTH + 1);
    localparam int SH_W        = $clog2(MAX_HEIGHT + 1);
    localparam int SWC_W       = (SW_W > SRC_DIM_W) ? SW_W : SRC_DIM_W;
    localparam int SHC_W       = (SH_W > SRC_DIM_W) ? SH_W : SRC_DIM_W;
    localparam int TOT_W       = (SW_W + SH_W > ADDR_W + 1) ? SW_W + SH_W : ADDR_W + 1;
    localparam int ROWP_W      = YW + SW_W;

    // Configuration registers.
    logic [SRC_DIM_W-1:0] r_src_width;
    logic [SRC_DIM_W-1:0] r_src_height;
    logic [DST_DIM_W-1:0] r_dst_width;
    logic [DST_DIM_W-1:0] r_dst_height;
    logic [STEP_W-1:0]    r_x_step;
    logic [STEP_W-1:0]    r_y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_DIM;
            r_src_height <= RST_SRC_DIM;
            r_dst_width  <= RST_DST_DIM;
            r_dst_height <= RST_DST_DIM;
            r_x_step     <= RST_STEP;
            r_y_step     <= RST_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DST_DIM_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DST_DIM_W-1:0];
                CFG_X_STEP:     r_x_step     <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP:     r_y_step     <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective source size, clamped to at least two and to the store's extent.
    logic [SWC_W-1:0] src_w_ext;
    logic [SHC_W-1:0] src_h_ext;
    logic [SW_W-1:0]  sw;
    logic [SH_W-1:0]  sh;
    logic [SW_W-1:0]  sw_dec;
    logic [SH_W-1:0]  sh_dec;
    logic [XW-1:0]    sw_m1;
    logic [YW-1:0]    sh_m1;

    assign src_w_ext = SWC_W'(r_src_width);
    assign src_h_ext = SHC_W'(r_src_height);

    always_comb begin
        if (src_w_ext < SWC_W'(2)) begin
            sw = SW_W'(2);
        end else if (src_w_ext > SWC_W'(MAX_WIDTH)) begin
            sw = SW_W'(MAX_WIDTH);
        end else begin
            sw = SW_W'(src_w_ext);
        end
        if (src_h_ext < SHC_W'(2)) begin
            sh = SH_W'(2);
        end else if (src_h_ext > SHC_W'(MAX_HEIGHT)) begin
            sh = SH_W'(MAX_HEIGHT);
        end else begin
            sh = SH_W'(src_h_ext);
        end
    end

    assign sw_dec = sw - SW_W'(1);
    assign sh_dec = sh - SH_W'(1);
    assign sw_m1  = sw_dec[XW-1:0];
    assign sh_m1  = sh_dec[YW-1:0];

    // Load position and emit counters.
    logic [ADDR_W-1:0]    r_load_pos;
    logic [ADDR_W-1:0]    n_load_pos;
    logic [TOT_W-1:0]     total;
    logic [TOT_W-1:0]     pos_inc;
    logic [DST_DIM_W-1:0] r_col;
    logic [DST_DIM_W-1:0] r_row;
    logic [DST_DIM_W-1:0] n_col;
    logic [DST_DIM_W-1:0] n_row;
    logic                 n_last;
    logic [DST_DIM_W-1:0] dw_m1;
    logic [DST_DIM_W-1:0] dh_m1;

    assign total   = TOT_W'(sw) * TOT_W'(sh);
    assign pos_inc = TOT_W'(r_load_pos) + TOT_W'(1);
    assign n_load_pos = (pos_inc >= total) ? '0 : pos_inc[ADDR_W-1:0];

    // A zero output size behaves as one.
    assign dw_m1 = (r_dst_width == '0) ? '0 : r_dst_width - DST_DIM_W'(1);
    assign dh_m1 = (r_dst_height == '0) ? '0 : r_dst_height - DST_DIM_W'(1);

    always_comb begin
        n_col  = r_col + DST_DIM_W'(1);
        n_row  = r_row;
        n_last = 1'b0;
        if (r_col >= dw_m1) begin
            n_col = '0;
            if (r_row >= dh_m1) begin
                n_row  = '0;
                n_last = 1'b1;
            end else begin
                n_row = r_row + DST_DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_load_pos <= n_load_pos;
            end
            if (i_cmd.emit) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Source position in Q20.16, taken from the counters before they advance.
    logic [PX_W-1:0] px_prod;
    logic [PX_W-1:0] py_prod;
    logic [PX_W-1:0] r_px;
    logic [PX_W-1:0] r_py;
    logic            r_last;

    assign px_prod = PX_W'(r_x_step) * PX_W'(r_col);
    assign py_prod = PX_W'(r_y_step) * PX_W'(r_row);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px   <= px_prod;
            r_py   <= py_prod;
            r_last <= n_last;
        end
    end

    // Neighbor coordinates, clamped to the last column and row.
    logic [IX_W-1:0]   ix;
    logic [IX_W-1:0]   iy;
    logic [XW-1:0]     x0;
    logic [XW-1:0]     x1;
    logic [YW-1:0]     y0;
    logic [YW-1:0]     y1;
    logic [XW-1:0]     r_x0;
    logic [XW-1:0]     r_x1;
    logic [YW-1:0]     r_y0;
    logic [YW-1:0]     r_y1;
    logic [FRAC_W-1:0] r_fx;
    logic [FRAC_W-1:0] r_fy;

    assign ix = r_px[PX_W-1:FRAC_W];
    assign iy = r_py[PX_W-1:FRAC_W];
    assign x0 = (ix > IX_W'(sw_m1)) ? sw_m1 : ix[XW-1:0];
    assign y0 = (iy > IX_W'(sh_m1)) ? sh_m1 : iy[YW-1:0];
    assign x1 = (x0 == sw_m1) ? x0 : x0 + XW'(1);
    assign y1 = (y0 == sh_m1) ? y0 : y0 + YW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_coord) begin
            r_x0 <= x0;
            r_x1 <= x1;
            r_y0 <= y0;
            r_y1 <= y1;
            r_fx <= r_px[FRAC_W-1:0];
            r_fy <= r_py[FRAC_W-1:0];
        end
    end

    // Row base addresses.
    logic [ROWP_W-1:0] row0_prod;
    logic [ROWP_W-1:0] row1_prod;
    logic [ADDR_W-1:0] r_row0;
    logic [ADDR_W-1:0] r_row1;

    assign row0_prod = ROWP_W'(r_y0) * ROWP_W'(sw);
    assign row1_prod = ROWP_W'(r_y1) * ROWP_W'(sw);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_rows) begin
            r_row0 <= row0_prod[ADDR_W-1:0];
            r_row1 <= row1_prod[ADDR_W-1:0];
        end
    end

    // Single-port frame store.
    logic [PIX_W-1:0]  mem [STORE_DEPTH];
    logic [PIX_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] mem_addr;

    always_comb begin
        unique case (i_cmd.rd_sel)
            NBR_A: rd_addr = r_row0 + ADDR_W'(r_x0);
            NBR_B: rd_addr = r_row0 + ADDR_W'(r_x1);
            NBR_C: rd_addr = r_row1 + ADDR_W'(r_x0);
            NBR_D: rd_addr = r_row1 + ADDR_W'(r_x1);
            default: rd_addr = r_row0 + ADDR_W'(r_x0);
        endcase
    end

    assign mem_addr = i_cmd.load ? r_load_pos : rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[mem_addr] <= {i_in_red, i_in_green, i_in_blue};
        end else if (i_cmd.rd_en) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // Blend: horizontal pass per row as the neighbors arrive, then vertical.
    logic [WGT_W-1:0] gx;
    logic [WGT_W-1:0] gy;
    logic [WGT_W-1:0] acc_w;
    logic [WGT_W-1:0] mix_w;
    logic [SUM_W-1:0] r_sum [NCH];

    assign gx    = WGT_ONE - WGT_W'(r_fx);
    assign gy    = WGT_ONE - WGT_W'(r_fy);
    assign acc_w = (i_cmd.acc_sel == NBR_A || i_cmd.acc_sel == NBR_C) ? gx : WGT_W'(r_fx);
    assign mix_w = i_cmd.mix_h ? WGT_W'(r_fy) : gy;

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        logic [CH_W-1:0]    rd_ch;
        logic [ACC_P_W-1:0] acc_prod;
        logic [ACC_W-1:0]   acc_sum;
        logic [ACC_W-1:0]   r_top;
        logic [ACC_W-1:0]   r_bot;
        logic [ACC_W-1:0]   mix_a;
        logic [MIX_P_W-1:0] mix_prod;
        logic [SUM_W-1:0]   mix_sum;

        assign rd_ch    = r_rd_data[c*CH_W +: CH_W];
        assign acc_prod = ACC_P_W'(rd_ch) * ACC_P_W'(acc_w);
        assign acc_sum  = ((i_cmd.acc_sel == NBR_B) ? r_top : r_bot)
                          + acc_prod[ACC_W-1:0];
        assign mix_a    = i_cmd.mix_h ? r_bot : r_top;
        assign mix_prod = MIX_P_W'(mix_a) * MIX_P_W'(mix_w);
        assign mix_sum  = r_sum[c] + mix_prod[SUM_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_cmd.acc_en) begin
                unique case (i_cmd.acc_sel)
                    NBR_A: r_top <= acc_prod[ACC_W-1:0];
                    NBR_B: r_top <= acc_sum;
                    NBR_C: r_bot <= acc_prod[ACC_W-1:0];
                    NBR_D: r_bot <= acc_sum;
                    default: r_top <= acc_prod[ACC_W-1:0];
                endcase
            end
            if (i_cmd.mix_v) begin
                r_sum[c] <= mix_prod[SUM_W-1:0];
            end else if (i_cmd.mix_h) begin
                r_sum[c] <= mix_sum;
            end
        end
    end

    // Output register; it frees the input side while a word waits downstream.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_red   <= r_sum[2][SUM_W-1 -: CH_W];
            o_out_green <= r_sum[1][SUM_W-1 -: CH_W];
            o_out_blue  <= r_sum[0][SUM_W-1 -: CH_W];
            o_out_last  <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

### hw/rtl/bilinear_image_scaler_core.sv
// Top level of the bilinear image scaler: controller plus datapath.
//
// Input channel i_in carries words with an opcode. A load word (opcode 0)
// writes its pixel into the frame store at the next raster position; the
// input stays open, so the next word may follow at once. An emit word
// (opcode 1) produces the next pixel of the scaled frame on o_out, with
// frame_last set on the final pixel of the frame.
// An emit runs through the single-port frame store, which is read four
// times, once for each neighbor, followed by the two blend steps; the result
// is then loaded into the output register, and the next word is accepted
// only after that, so a new word is not taken while an emit is in progress.
// If the receiver stalls, the result waits in the output register; a
// further emit finishes its work and then holds until that register frees.
// Writes on i_cfg_* take effect at once; the user must make them while the
// block is idle, which it does not enforce. Synchronous reset restores the
// register defaults and clears the load position and output counters; the
// frame store keeps its contents and must be loaded before it is read.
module bilinear_image_scaler_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bis_in_if.sink                         i_in,
    bis_out_if.source                      o_out
);
    import bis_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bis_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_red    (i_in.in_red),
        .i_in_green  (i_in.in_green),
        .i_in_blue   (i_in.in_blue),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_red   (o_out.out_red),
        .o_out_green (o_out.out_green),
        .o_out_blue  (o_out.out_blue),
        .o_out_last  (o_out.frame_last)
    );

    assign i_in.ready = cmd.in_ready;

endmodule

### hw/rtl/bis_checker.sv
// Port-level checker for the bilinear scaler, bound to the top level.
`include "bilinear_image_scaler_core_defines.svh"

module bis_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_in_opcode,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [bis_pkg::CH_W-1:0] i_out_red,
    input logic [bis_pkg::CH_W-1:0] i_out_green,
    input logic [bis_pkg::CH_W-1:0] i_out_blue,
    input logic                     i_out_last
);
    import bis_pkg::*;

    // An accepted emit keeps the block busy in the following cycle.
    `BIS_ASSERT_NEXT(a_emit_busy, i_in_valid && i_in_ready && i_in_opcode == OP_EMIT, !i_in_ready)

    // An accepted load leaves the input open in the following cycle.
    `BIS_ASSERT_NEXT(a_load_open, i_in_valid && i_in_ready && i_in_opcode == OP_LOAD, i_in_ready)

    // A new result word only appears after the block was busy on an emit.
    `BIS_ASSERT_SAME(a_out_after_busy, $rose(i_out_valid), $past(!i_in_ready))

    // A stalled result word holds its payload.
    `BIS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue) && $stable(i_out_last))

endmodule

bind bilinear_image_scaler_core bis_checker u_bis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_red   (o_out.out_red),
    .i_out_green (o_out.out_green),
    .i_out_blue  (o_out.out_blue),
    .i_out_last  (o_out.frame_last)
);
